// ----- rtl/rrpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rrpf_pkg: shared types and constants of the range rule packet filter
// Opcodes, status codes, the rule record and the query beat that walks the
// row of rule cells.
// ----------------------------------------------------------------------------
package rrpf_pkg;

    localparam int RULE_SLOTS_DEF = 128;
    localparam int HIT_LIMIT_DEF  = 100;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 7;
    localparam int HITS_W   = 7;

    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_start;
        logic [ADDR_W-1:0] addr_end;
        logic [PORT_W-1:0] port_start;
        logic [PORT_W-1:0] port_end;
    } t_rule;

    // query beat handed from cell to cell
    typedef struct packed {
        logic                vld;
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr_low;
        logic [ADDR_W-1:0]   addr_high;
        logic [PORT_W-1:0]   port_low;
        logic [PORT_W-1:0]   port_high;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  rule_index;
        logic [HITS_W-1:0]   hit_count;
    } t_token;

endpackage

// ----- rtl/rrpf_ifs.sv -----
// ----------------------------------------------------------------------------
// rrpf_ifs: request and response channels of the range rule packet filter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rrpf_req_if;
    logic                          valid;
    logic                          ready;
    logic [rrpf_pkg::OP_W-1:0]     op;
    logic [rrpf_pkg::ADDR_W-1:0]   addr_low;
    logic [rrpf_pkg::ADDR_W-1:0]   addr_high;
    logic [rrpf_pkg::PORT_W-1:0]   port_low;
    logic [rrpf_pkg::PORT_W-1:0]   port_high;

    modport source (output valid, op, addr_low, addr_high, port_low, port_high,
                    input ready);
    modport sink (input valid, op, addr_low, addr_high, port_low, port_high,
                  output ready);
endinterface

interface rrpf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rrpf_pkg::STATUS_W-1:0] status;
    logic [rrpf_pkg::INDEX_W-1:0]  rule_index;
    logic [rrpf_pkg::HITS_W-1:0]   hit_count;

    modport source (output valid, status, rule_index, hit_count, input ready);
    modport sink (input valid, status, rule_index, hit_count, output ready);
endinterface

// ----- rtl/range_rule_packet_filter_top.sv -----
// ----------------------------------------------------------------------------
// range_rule_packet_filter_top: first-match address/port range rule table
// Path: a request beat is registered at entry, in each rule cell and in the
//   response output register; one cell per cycle along the row. A new request
//   enters once the beat has left the row and the skid stage is empty.
// Reset (synchronous, active low) empties the table, idles the sequencer and
//   drops pending responses; rule storage itself is not cleared.
// ----------------------------------------------------------------------------
module range_rule_packet_filter_top #(
    parameter int RULE_SLOTS = rrpf_pkg::RULE_SLOTS_DEF,
    parameter int HIT_LIMIT  = rrpf_pkg::HIT_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrpf_req_if.sink    i_req,
    rrpf_rsp_if.source  o_rsp
);
    import rrpf_pkg::*;

    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam int HIT_W = $clog2(HIT_LIMIT + 1);

    // state
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_token           r_head;
    t_token           n_head;

    // response output register and skid stage
    logic             r_out_vld;
    t_token           r_out;
    logic             r_skid_vld;
    t_token           r_skid;

    // cell row wiring: w_tok[i] enters cell i, w_tok[RULE_SLOTS] leaves the row
    t_token           w_tok  [RULE_SLOTS+1];
    t_rule            w_rule [RULE_SLOTS+1];
    logic [HIT_W-1:0] w_hits [RULE_SLOTS+1];

    t_token           tail;
    t_token           fin;
    logic             req_take;
    logic             rsp_take;

    assign i_req.ready = (r_state == S_IDLE) && !r_skid_vld;
    assign req_take    = i_req.valid && i_req.ready;
    assign rsp_take    = r_out_vld && o_rsp.ready;

    // ------------------------------------------------------------------
    // Entry: settle the add checks that need only the count and the bounds,
    // and reject the unused opcode before the beat enters the row.
    // ------------------------------------------------------------------
    always_comb begin
        n_head            = '0;
        n_head.vld        = req_take;
        n_head.op         = i_req.op;
        n_head.addr_low   = i_req.addr_low;
        n_head.addr_high  = i_req.addr_high;
        n_head.port_low   = i_req.port_low;
        n_head.port_high  = i_req.port_high;
        case (i_req.op)
            OP_CHECK, OP_DEL: begin
            end
            OP_ADD: begin
                if (r_count >= CNT_W'(RULE_SLOTS)) begin
                    // fullness wins over a reversed range
                    n_head.done   = 1'b1;
                    n_head.status = ST_FULL;
                end else if ((i_req.addr_low > i_req.addr_high)
                          || (i_req.port_low > i_req.port_high)) begin
                    n_head.done   = 1'b1;
                    n_head.status = ST_INVALID;
                end
            end
            default: begin
                n_head.done   = 1'b1;
                n_head.status = ST_REJECTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else begin
            r_head <= n_head;
        end
    end

    assign w_tok[0] = r_head;

    // ------------------------------------------------------------------
    // Row of rule cells; the last cell pulls its own content on a delete,
    // which leaves a stale entry beyond the count.
    // ------------------------------------------------------------------
    generate
        for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
            rrpf_cell #(
                .SLOT       (g),
                .RULE_SLOTS (RULE_SLOTS),
                .HIT_LIMIT  (HIT_LIMIT),
                .CNT_W      (CNT_W),
                .HIT_W      (HIT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_count     (r_count),
                .i_tok       (w_tok[g]),
                .o_tok       (w_tok[g+1]),
                .i_next_rule (w_rule[g+1]),
                .i_next_hits (w_hits[g+1]),
                .o_rule      (w_rule[g]),
                .o_hits      (w_hits[g])
            );
        end
    endgenerate

    assign w_rule[RULE_SLOTS] = w_rule[RULE_SLOTS-1];
    assign w_hits[RULE_SLOTS] = w_hits[RULE_SLOTS-1];

    // ------------------------------------------------------------------
    // Exit: a beat that found nothing is rejected or not found.
    // ------------------------------------------------------------------
    assign tail = w_tok[RULE_SLOTS];

    always_comb begin
        fin = tail;
        if (!tail.done) begin
            fin.rule_index = '0;
            fin.hit_count  = '0;
            case (tail.op)
                OP_DEL:  fin.status = ST_NOTFOUND;
                default: fin.status = ST_REJECTED;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (tail.vld && (fin.status == ST_ADDED)) begin
            n_count = r_count + CNT_W'(1);
        end else if (tail.vld && (fin.status == ST_DELETED)) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: one beat in the row at a time.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (tail.vld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Response: output register with a skid stage behind it, so a new
    // request can enter while a finished response waits.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld && (!r_out_vld || rsp_take)) begin
                r_out_vld  <= 1'b1;
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end else if (tail.vld && (!r_out_vld || rsp_take)) begin
                r_out_vld <= 1'b1;
                r_out     <= fin;
            end else if (rsp_take) begin
                r_out_vld <= 1'b0;
            end
            if (tail.vld && r_out_vld && !rsp_take) begin
                r_skid_vld <= 1'b1;
                r_skid     <= fin;
            end
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.rule_index = r_out.rule_index;
    assign o_rsp.hit_count  = r_out.hit_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_tail_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> (r_state == S_RUN))
        else $error("beat left the cell row while the sequencer was idle");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage holds a response with the output register empty");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RULE_SLOTS))
        else $error("rule count beyond table size");

    a_count_only_at_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tail.vld |=> $stable(r_count))
        else $error("rule count changed with no beat leaving the row");

    a_add_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.vld && (fin.status == ST_ADDED)) |-> (r_count < CNT_W'(RULE_SLOTS)))
        else $error("rule added to a full table");

endmodule

// ----- rtl/rrpf_cell.sv -----
// ----------------------------------------------------------------------------
// rrpf_cell: one rule slot of the filter row
// Holds one rule and its hit count, serves the query beat passing through,
// and pulls the rule of its right neighbor while a delete closes the gap.
// ----------------------------------------------------------------------------
module rrpf_cell #(
    parameter int SLOT       = 0,
    parameter int RULE_SLOTS = rrpf_pkg::RULE_SLOTS_DEF,
    parameter int HIT_LIMIT  = rrpf_pkg::HIT_LIMIT_DEF,
    parameter int CNT_W      = $clog2(RULE_SLOTS + 1),
    parameter int HIT_W      = $clog2(HIT_LIMIT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_count,
    input  rrpf_pkg::t_token   i_tok,
    output rrpf_pkg::t_token   o_tok,
    input  rrpf_pkg::t_rule    i_next_rule,
    input  logic [HIT_W-1:0]   i_next_hits,
    output rrpf_pkg::t_rule    o_rule,
    output logic [HIT_W-1:0]   o_hits
);
    import rrpf_pkg::*;

    t_rule            r_rule;
    logic [HIT_W-1:0] r_hits;
    t_token           r_tok;
    t_token           n_tok;
    t_rule            n_rule;
    logic [HIT_W-1:0] n_hits;
    logic             live;
    logic             in_range;
    logic             exact;
    logic             shift;
    logic [HIT_W-1:0] bumped;
    logic [31:0]      bumped_ext;

    assign live     = CNT_W'(SLOT) < i_count;
    assign in_range = (i_tok.addr_low >= r_rule.addr_start)
                   && (i_tok.addr_low <= r_rule.addr_end)
                   && (i_tok.port_low >= r_rule.port_start)
                   && (i_tok.port_low <= r_rule.port_end);
    assign exact    = (i_tok.addr_low == r_rule.addr_start)
                   && (i_tok.addr_high == r_rule.addr_end)
                   && (i_tok.port_low == r_rule.port_start)
                   && (i_tok.port_high == r_rule.port_end);
    assign bumped     = (r_hits < HIT_W'(HIT_LIMIT)) ? r_hits + HIT_W'(1) : r_hits;
    assign bumped_ext = 32'(bumped);

    // the beat leaving this cell marks a deleted rule at or before this slot
    assign shift = r_tok.vld && (r_tok.op == OP_DEL) && r_tok.done
                && (r_tok.status == ST_DELETED);

    always_comb begin
        n_tok  = i_tok;
        n_rule = r_rule;
        n_hits = r_hits;
        if (shift) begin
            n_rule = i_next_rule;
            n_hits = i_next_hits;
        end
        if (i_tok.vld && !i_tok.done) begin
            case (i_tok.op)
                OP_CHECK: begin
                    if (live && in_range) begin
                        n_hits           = bumped;
                        n_tok.done       = 1'b1;
                        n_tok.status     = ST_ACCEPTED;
                        n_tok.rule_index = INDEX_W'(SLOT);
                        n_tok.hit_count  = bumped_ext[HITS_W-1:0];
                    end
                end
                OP_ADD: begin
                    if (CNT_W'(SLOT) == i_count) begin
                        n_rule.addr_start = i_tok.addr_low;
                        n_rule.addr_end   = i_tok.addr_high;
                        n_rule.port_start = i_tok.port_low;
                        n_rule.port_end   = i_tok.port_high;
                        n_hits            = '0;
                        n_tok.done        = 1'b1;
                        n_tok.status      = ST_ADDED;
                        n_tok.rule_index  = INDEX_W'(SLOT);
                    end
                end
                OP_DEL: begin
                    if (live && exact) begin
                        n_tok.done       = 1'b1;
                        n_tok.status     = ST_DELETED;
                        n_tok.rule_index = INDEX_W'(SLOT);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rule <= n_rule;
        r_hits <= n_hits;
    end

    assign o_tok  = r_tok;
    assign o_rule = r_rule;
    assign o_hits = r_hits;

endmodule
